// ===== hw/rtl/text_console_writer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the text console writer checker
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH

// Same-cycle implication
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer files.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Store geometry
  localparam int MAX_COLS    = 80;
  localparam int MAX_ROWS    = 25;
  localparam int STORE_CELLS = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(STORE_CELLS);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [6:0]        col_t;
  typedef logic [4:0]        row_t;
  typedef logic [15:0]       cell_t;
  typedef logic [11:0]       offs_t;

  localparam col_t  COLS_MAX    = col_t'(MAX_COLS);
  localparam row_t  ROWS_MAX    = row_t'(MAX_ROWS);
  localparam addr_t STORE_LIMIT = addr_t'(STORE_CELLS);
  localparam offs_t SCREEN_STRIDE = offs_t'(80);

  // Character codes
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] RESET_COLOR  = 8'd15;
  localparam cell_t      RESET_BLANK  = {RESET_COLOR, CH_SPACE};

  // Register indexes
  localparam logic [2:0] CFG_PANE_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_PANE_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_TEXT_COLOR  = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_COL  = 3'd3;
  localparam logic [2:0] CFG_ORIGIN_ROW  = 3'd4;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCROLL,
    ST_READ
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_t;

  typedef struct packed {
    cell_t cell_value;
    row_t  cursor_row;
    col_t  cursor_col;
    offs_t cursor_offset;
  } out_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    cell_t data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcw_cell_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cell_ram (
  input  wire logic            clk,
  input  wire tcw_pkg::mem_wr_t wr,
  input  wire tcw_pkg::addr_t  rd_addr,
  output tcw_pkg::cell_t       rd_data
);

  tcw_pkg::cell_t mem [tcw_pkg::STORE_CELLS];

  // Write one word and read one word per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text pane engine: cell store with cursor, wrap and scroll.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: item is taken on a clock edge with start high and busy
//   low. Commands are write character, clear pane and read one cell.
//   Result channel: done pulses for one cycle with result valid; there is no
//   backpressure. Every command gives exactly one result.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
//   always high. Write registers only while busy is low.
// Command flow (accept to done):
//   plain write, backspace, newline, no-op: ST_EXEC; read: ST_EXEC, ST_READ.
//   clear: ST_EXEC, ST_CLEAR over width*height cells (one cell written per cycle).
//   scroll: ST_EXEC, ST_SCROLL, a read-then-write pipeline through the
//   single-port-per-direction cell memory moving one cell per cycle.
// Reset: rst clears the cursor, loads register defaults and sweeps all 2000
//   cells to a blank in color 15, one per cycle; busy is high during the
//   sweep, and configuration writes are still taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire tcw_pkg::in_t item,
  output logic              done,
  output tcw_pkg::out_t     result,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [7:0]   cfg_data
);

  tcw_pkg::state_e state, state_next;

  // Configuration registers
  tcw_pkg::col_t pane_width;
  tcw_pkg::row_t pane_height;
  logic [7:0]    text_color;
  tcw_pkg::col_t origin_col;
  tcw_pkg::row_t origin_row;

  // Cursor and working registers
  tcw_pkg::row_t  cur_row;
  tcw_pkg::col_t  cur_col;
  tcw_pkg::in_t   item_q;
  tcw_pkg::addr_t cnt;
  tcw_pkg::addr_t lim;
  tcw_pkg::addr_t copy_lim;
  tcw_pkg::cell_t fill;
  logic           pipe_v;
  logic           pipe_copy;
  tcw_pkg::addr_t pipe_addr;
  logic           rd_ok;
  tcw_pkg::out_t  res;

  // Memory ports
  tcw_pkg::mem_wr_t mem_wr;
  tcw_pkg::addr_t   rd_addr;
  tcw_pkg::cell_t   rd_data;

  // Command datapath
  tcw_pkg::col_t    w_eff;
  tcw_pkg::row_t    h_eff;
  tcw_pkg::row_t    row_c;
  tcw_pkg::col_t    col_c;
  logic [11:0]      base_prod;
  logic [11:0]      area_prod;
  tcw_pkg::addr_t   base;
  tcw_pkg::row_t    row_n;
  tcw_pkg::col_t    col_n;
  logic [5:0]       row_w;
  logic [7:0]       col_w;
  logic             scroll;
  tcw_pkg::mem_wr_t exec_wr;
  tcw_pkg::cell_t   blank;
  logic [5:0]       sum_r;
  tcw_pkg::offs_t   offset;
  logic             sweep_last;
  logic             scroll_last;

  tcw_cell_ram u_ram (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Clamp pane size and cursor
  always_comb begin
    w_eff = pane_width;
    if (pane_width == '0) begin
      w_eff = tcw_pkg::col_t'(1);
    end else if (pane_width > tcw_pkg::COLS_MAX) begin
      w_eff = tcw_pkg::COLS_MAX;
    end
    h_eff = pane_height;
    if (pane_height == '0) begin
      h_eff = tcw_pkg::row_t'(1);
    end else if (pane_height > tcw_pkg::ROWS_MAX) begin
      h_eff = tcw_pkg::ROWS_MAX;
    end
    row_c = (cur_row >= h_eff) ? h_eff - 5'd1 : cur_row;
    col_c = (cur_col >= w_eff) ? w_eff - 7'd1 : cur_col;
  end

  assign blank     = {text_color, tcw_pkg::CH_SPACE};
  assign base_prod = {7'd0, row_c} * {5'd0, w_eff};
  assign area_prod = {7'd0, h_eff} * {5'd0, w_eff};
  assign base      = base_prod[tcw_pkg::ADDR_W-1:0] + tcw_pkg::addr_t'(col_c);

  // Work out the new cursor and the cell write of one command
  always_comb begin
    row_n   = row_c;
    col_n   = col_c;
    row_w   = {1'b0, row_c};
    col_w   = {1'b0, col_c};
    scroll  = 1'b0;
    exec_wr = '0;
    unique case (item_q.cmd)
      tcw_pkg::CMD_WRITE: begin
        if (item_q.char_code == tcw_pkg::CH_BACKSPACE) begin
          // Step back one cell, wrapping to the previous row end
          if (col_c != '0) begin
            col_n = col_c - 7'd1;
          end else if (row_c != '0) begin
            row_n = row_c - 5'd1;
            col_n = w_eff - 7'd1;
          end
          exec_wr.en   = 1'b1;
          exec_wr.addr = (row_c == '0 && col_c == '0) ? base : base - 11'd1;
          exec_wr.data = blank;
        end else begin
          if (item_q.char_code == tcw_pkg::CH_NEWLINE) begin
            col_w = '0;
            row_w = {1'b0, row_c} + 6'd1;
          end else begin
            exec_wr.en   = 1'b1;
            exec_wr.addr = base;
            exec_wr.data = {text_color, item_q.char_code};
            col_w        = {1'b0, col_c} + 8'd1;
          end
          // Wrap at the right edge
          if (col_w >= {1'b0, w_eff}) begin
            col_w = '0;
            row_w = row_w + 6'd1;
          end
          // Scroll past the bottom edge
          if (row_w >= {1'b0, h_eff}) begin
            scroll = 1'b1;
            row_n  = h_eff - 5'd1;
          end else begin
            row_n = row_w[4:0];
          end
          col_n = col_w[6:0];
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        row_n = '0;
        col_n = '0;
      end
      tcw_pkg::CMD_READ: begin
      end
      tcw_pkg::CMD_NOP: begin
      end
    endcase
  end

  // Screen offset of the final cursor
  assign sum_r  = {1'b0, origin_row} + {1'b0, row_n};
  assign offset = tcw_pkg::offs_t'({6'd0, sum_r} * tcw_pkg::SCREEN_STRIDE)
                + tcw_pkg::offs_t'(origin_col) + tcw_pkg::offs_t'(col_n);

  assign sweep_last  = (cnt == lim - 11'd1);
  assign scroll_last = pipe_v && (pipe_addr == lim - 11'd1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcw_pkg::ST_INIT: begin
        if (sweep_last) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (start) state_next = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        priority if (item_q.cmd == tcw_pkg::CMD_CLEAR) begin
          state_next = tcw_pkg::ST_CLEAR;
        end else if (item_q.cmd == tcw_pkg::CMD_READ) begin
          state_next = tcw_pkg::ST_READ;
        end else if (scroll) begin
          state_next = tcw_pkg::ST_SCROLL;
        end else begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        if (sweep_last) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_SCROLL: begin
        if (scroll_last) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_READ: begin
        state_next = tcw_pkg::ST_IDLE;
      end
      default: state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  // Outputs and memory port selection
  always_comb begin
    busy    = (state != tcw_pkg::ST_IDLE);
    mem_wr  = '0;
    rd_addr = '0;
    unique case (state)
      tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = cnt;
        mem_wr.data = fill;
      end
      tcw_pkg::ST_EXEC: begin
        mem_wr = exec_wr;
        if (item_q.cell_index < tcw_pkg::STORE_LIMIT) begin
          rd_addr = item_q.cell_index;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        mem_wr.en   = pipe_v;
        mem_wr.addr = pipe_addr;
        mem_wr.data = pipe_copy ? rd_data : fill;
        if (cnt < copy_lim) begin
          rd_addr = cnt + tcw_pkg::addr_t'(w_eff);
        end
      end
      default: begin
      end
    endcase
  end

  assign cfg_ready = 1'b1;
  assign result    = res;

  // State, registers and sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tcw_pkg::ST_INIT;
      pane_width  <= tcw_pkg::COLS_MAX;
      pane_height <= tcw_pkg::ROWS_MAX;
      text_color  <= tcw_pkg::RESET_COLOR;
      origin_col  <= '0;
      origin_row  <= '0;
      cur_row     <= '0;
      cur_col     <= '0;
      item_q      <= '0;
      cnt         <= '0;
      lim         <= tcw_pkg::STORE_LIMIT;
      copy_lim    <= '0;
      fill        <= tcw_pkg::RESET_BLANK;
      pipe_v      <= 1'b0;
      done        <= 1'b0;
    end else begin
      state <= state_next;

      // Take configuration words
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tcw_pkg::CFG_PANE_WIDTH:  pane_width  <= cfg_data[6:0];
          tcw_pkg::CFG_PANE_HEIGHT: pane_height <= cfg_data[4:0];
          tcw_pkg::CFG_TEXT_COLOR:  text_color  <= cfg_data;
          tcw_pkg::CFG_ORIGIN_COL:  origin_col  <= cfg_data[6:0];
          tcw_pkg::CFG_ORIGIN_ROW:  origin_row  <= cfg_data[4:0];
          default: begin
          end
        endcase
      end

      unique case (state)
        tcw_pkg::ST_IDLE: begin
          done <= 1'b0;
          if (start) item_q <= item;
        end
        tcw_pkg::ST_EXEC: begin
          cur_row           <= row_n;
          cur_col           <= col_n;
          res.cell_value    <= '0;
          res.cursor_row    <= row_n;
          res.cursor_col    <= col_n;
          res.cursor_offset <= offset;
          cnt               <= '0;
          lim               <= area_prod[tcw_pkg::ADDR_W-1:0];
          copy_lim          <= area_prod[tcw_pkg::ADDR_W-1:0]
                               - tcw_pkg::addr_t'(w_eff);
          fill              <= blank;
          pipe_v            <= 1'b0;
          rd_ok             <= (item_q.cell_index < tcw_pkg::STORE_LIMIT);
          done              <= (state_next == tcw_pkg::ST_IDLE);
        end
        tcw_pkg::ST_INIT: begin
          cnt  <= cnt + 11'd1;
          done <= 1'b0;
        end
        tcw_pkg::ST_CLEAR: begin
          cnt  <= cnt + 11'd1;
          done <= sweep_last;
        end
        tcw_pkg::ST_SCROLL: begin
          // Issue one read ahead, write it back one row up next cycle
          if (cnt < lim) begin
            pipe_v    <= 1'b1;
            pipe_addr <= cnt;
            pipe_copy <= (cnt < copy_lim);
            cnt       <= cnt + 11'd1;
          end else begin
            pipe_v <= 1'b0;
          end
          done <= scroll_last;
        end
        tcw_pkg::ST_READ: begin
          res.cell_value <= rd_ok ? rd_data : '0;
          done           <= 1'b1;
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_unit_macros.svh"

module tcw_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done,
  input wire tcw_pkg::out_t result
);

  // Store sweep after reset holds off commands
  `TCW_ASSERT_NOW(a_init_busy, $past(rst), busy, "not busy right after reset")

  // An accepted word keeps the block busy in the next cycle
  `TCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word not started")

  // Result strobe is one cycle wide
  `TCW_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

  // Result shows with the block free and the cursor inside the store
  `TCW_ASSERT_NOW(a_done_cursor, done,
    !busy && result.cursor_row < tcw_pkg::ROWS_MAX &&
    result.cursor_col < tcw_pkg::COLS_MAX,
    "result strobe with bad cursor or while busy")

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
